>>> sv/qte_pkg.sv
// Shared types and constants for the quaternion to Euler angle converter.
// Used by qte_cordic and quaternion_to_euler_angles; depends on nothing.
`default_nettype none
package qte_pkg;

   localparam int CORDIC_ITERS = 16;
   localparam int CORDIC_LAT   = CORDIC_ITERS + 2;
   localparam int SQRT_STEPS   = 29;
   localparam int VEC_W        = 38;
   localparam int ANG_W        = 21;
   localparam int OUT_W        = 18;
   localparam int TRIG_W       = 34;

   localparam logic signed [ANG_W-1:0] ANG_PI_Q16  = 21'sd205887;
   localparam logic signed [OUT_W-1:0] PI_Q13      = 18'sd25736;
   localparam logic signed [OUT_W-1:0] HALF_PI_Q13 = 18'sd12868;

   localparam logic signed [ANG_W-1:0] ATAN_TAB [CORDIC_ITERS] = '{
      21'sd51472, 21'sd30386, 21'sd16055, 21'sd8150, 21'sd4091, 21'sd2047,
      21'sd1024, 21'sd512, 21'sd256, 21'sd128, 21'sd64, 21'sd32, 21'sd16,
      21'sd8, 21'sd4, 21'sd2
   };

   typedef struct packed {
      logic signed [TRIG_W-1:0] sinr;
      logic signed [TRIG_W-1:0] cosr;
      logic signed [TRIG_W-1:0] siny;
      logic signed [TRIG_W-1:0] cosy;
      logic signed [TRIG_W-1:0] sinp;
   } trig_type;

   typedef struct packed {
      logic sat;
      logic neg;
   } side_type;

endpackage
`default_nettype wire

>>> sv/qte_cordic.sv
// Pipelined vectoring CORDIC: atan2(vec_y, vec_x) in Q5.13, before clamping.
// Input register, iteration registers and output register, all advancing only on en; uses qte_pkg.
`default_nettype none
module qte_cordic (
   input  wire                                      clock,
   input  wire                                      en,
   input  wire  logic signed [qte_pkg::VEC_W-1:0]   vec_y,
   input  wire  logic signed [qte_pkg::VEC_W-1:0]   vec_x,
   output logic signed [qte_pkg::OUT_W-1:0]         angle
);

   localparam int N = qte_pkg::CORDIC_ITERS;

   logic signed [qte_pkg::VEC_W-1:0] x_ff [0:N];
   logic signed [qte_pkg::VEC_W-1:0] y_ff [0:N];
   logic signed [qte_pkg::ANG_W-1:0] z_ff [0:N];
   logic                             special_ff [0:N];
   logic signed [qte_pkg::OUT_W-1:0] sval_ff [0:N];
   logic signed [qte_pkg::OUT_W-1:0] angle_ff;

   logic                             special_in;
   logic signed [qte_pkg::OUT_W-1:0] sval_in;
   logic signed [qte_pkg::VEC_W-1:0] x_in;
   logic signed [qte_pkg::VEC_W-1:0] y_in;
   logic signed [qte_pkg::ANG_W-1:0] z_in;
   logic signed [qte_pkg::ANG_W-1:0] zr;

   // axis cases bypass the iterations; left half plane folds by pi
   always_comb begin
      special_in = 1'b0;
      sval_in    = '0;
      x_in       = vec_x;
      y_in       = vec_y;
      z_in       = '0;
      if (vec_y == '0) begin
         special_in = 1'b1;
         sval_in    = (vec_x < 0) ? qte_pkg::PI_Q13 : '0;
      end else if (vec_x == '0) begin
         special_in = 1'b1;
         sval_in    = (vec_y > 0) ? qte_pkg::HALF_PI_Q13 : -qte_pkg::HALF_PI_Q13;
      end else if (vec_x < 0) begin
         x_in = -vec_x;
         y_in = -vec_y;
         z_in = (vec_y > 0) ? qte_pkg::ANG_PI_Q16 : -qte_pkg::ANG_PI_Q16;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]       <= x_in;
         y_ff[0]       <= y_in;
         z_ff[0]       <= z_in;
         special_ff[0] <= special_in;
         sval_ff[0]    <= sval_in;
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_iter
      always_ff @(posedge clock) begin
         if (en) begin
            if (y_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + qte_pkg::ATAN_TAB[i];
            end else begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - qte_pkg::ATAN_TAB[i];
            end
            special_ff[i+1] <= special_ff[i];
            sval_ff[i+1]    <= sval_ff[i];
         end
      end
   end

   // round half up from Q16 to Q13
   assign zr = (z_ff[N] + 21'sd4) >>> 3;

   always_ff @(posedge clock) begin
      if (en) begin
         angle_ff <= special_ff[N] ? sval_ff[N] : zr[qte_pkg::OUT_W-1:0];
      end
   end

   assign angle = angle_ff;

endmodule
`default_nettype wire

>>> sv/quaternion_to_euler_angles.sv
// Quaternion (Q2.14) to roll/yaw (Q3.13) and pitch (Q2.13) converter, top level.
// Pipeline: 4 product/sum stages, 29 square-root digit stages,
// 18 CORDIC stages and one output register. Throughput one word per cycle.
// The whole pipe holds while the output word waits on rsp_tready.
// Synchronous active-high reset clears the valid bits only; no other state.
// Depends on qte_pkg and qte_cordic.
`default_nettype none
module quaternion_to_euler_angles (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [63:0] req_tdata,   // quat_w[15:0], quat_x[31:16], quat_y[47:32], quat_z[63:48]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [47:0] rsp_tdata,   // roll_angle[15:0], pitch_angle[30:16], yaw_angle[46:31], 0
   output logic        rsp_tuser    // pitch_saturated
);

   localparam int SQ  = qte_pkg::SQRT_STEPS;
   localparam int TW  = qte_pkg::TRIG_W;
   localparam int VW  = qte_pkg::VEC_W;
   localparam int OW  = qte_pkg::OUT_W;
   localparam int LAT = 4 + SQ + qte_pkg::CORDIC_LAT + 1;
   localparam int SIDE_LEN = 1 + SQ + qte_pkg::CORDIC_LAT;
   localparam int RW  = 2 * SQ - 1;   // remainder width

   logic en;
   logic valid_ff [0:LAT-1];

   logic signed [15:0] qw, qx, qy, qz;
   logic signed [31:0] wx_ff, yz_ff, xx_ff, yy_ff, wz_ff, xy_ff, zz_ff, wy_ff, zx_ff;

   qte_pkg::trig_type trig_in;
   qte_pkg::trig_type trig2_ff;
   qte_pkg::trig_type trig3_ff;
   qte_pkg::side_type side_in;
   qte_pkg::side_type side2_ff;
   logic [27:0]       mag2_ff;
   logic [TW-1:0]     mag;
   logic [55:0]       msq;

   qte_pkg::trig_type trig_ff [0:SQ];
   logic [RW-1:0]     rem_ff  [0:SQ];
   logic [SQ-1:0]     root_ff [0:SQ];
   qte_pkg::side_type side_ff [0:SIDE_LEN-1];

   logic signed [OW-1:0] roll_r, pitch_r, yaw_r;
   logic [15:0] roll_ff, yaw_ff;
   logic [14:0] pitch_ff;
   logic        sat_ff;
   logic signed [OW-1:0] pitch_c;

   assign en         = !valid_ff[LAT-1] || rsp_tready;
   assign req_tready = en;

   assign qw = req_tdata[15:0];
   assign qx = req_tdata[31:16];
   assign qy = req_tdata[47:32];
   assign qz = req_tdata[63:48];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) valid_ff[i] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= req_tvalid;
         for (int i = 1; i < LAT; i++) valid_ff[i] <= valid_ff[i-1];
      end
   end

   // stage 1: products
   always_ff @(posedge clock) begin
      if (en) begin
         wx_ff <= qw * qx;
         yz_ff <= qy * qz;
         xx_ff <= qx * qx;
         yy_ff <= qy * qy;
         wz_ff <= qw * qz;
         xy_ff <= qx * qy;
         zz_ff <= qz * qz;
         wy_ff <= qw * qy;
         zx_ff <= qz * qx;
      end
   end

   // stage 2: sine/cosine terms at scale 2^28
   always_comb begin
      trig_in.sinr = (TW'(wx_ff) + TW'(yz_ff)) <<< 1;
      trig_in.cosr = (TW'(1) <<< 28) - ((TW'(xx_ff) + TW'(yy_ff)) <<< 1);
      trig_in.siny = (TW'(wz_ff) + TW'(xy_ff)) <<< 1;
      trig_in.cosy = (TW'(1) <<< 28) - ((TW'(yy_ff) + TW'(zz_ff)) <<< 1);
      trig_in.sinp = (TW'(wy_ff) - TW'(zx_ff)) <<< 1;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         trig2_ff <= trig_in;
      end
   end

   assign mag = trig2_ff.sinp[TW-1] ? TW'(-trig2_ff.sinp) : TW'(trig2_ff.sinp);

   // stage 3 inputs: |s| >= 1 clamps pitch, square-root operand forced to one
   always_comb begin
      side_in.sat = |mag[TW-1:28];
      side_in.neg = trig2_ff.sinp[TW-1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side2_ff <= side_in;
         mag2_ff  <= side_in.sat ? 28'd0 : mag[27:0];
         trig3_ff <= trig2_ff;
      end
   end

   assign msq = mag2_ff * mag2_ff;

   // stage 4: operand 1 - s^2 at scale 2^56
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= (RW'(1) << 56) - RW'(msq);
         root_ff[0] <= '0;
         trig_ff[0] <= trig3_ff;
         side_ff[0] <= side2_ff;
      end
   end

   // floor square root, one result bit per stage from the top
   for (genvar j = 0; j < SQ; j++) begin : g_sqrt
      localparam int K = SQ - 1 - j;
      logic [RW:0] trial;
      assign trial = ((RW+1)'(root_ff[j]) << (K + 1)) + ((RW+1)'(1) << (2 * K));
      always_ff @(posedge clock) begin
         if (en) begin
            if ({1'b0, rem_ff[j]} >= trial) begin
               rem_ff[j+1]  <= rem_ff[j] - trial[RW-1:0];
               root_ff[j+1] <= root_ff[j] | (SQ'(1) << K);
            end else begin
               rem_ff[j+1]  <= rem_ff[j];
               root_ff[j+1] <= root_ff[j];
            end
            trig_ff[j+1] <= trig_ff[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 1; i < SIDE_LEN; i++) side_ff[i] <= side_ff[i-1];
      end
   end

   qte_cordic u_roll (
      .clock (clock),
      .en    (en),
      .vec_y (VW'(trig_ff[SQ].sinr)),
      .vec_x (VW'(trig_ff[SQ].cosr)),
      .angle (roll_r)
   );

   qte_cordic u_pitch (
      .clock (clock),
      .en    (en),
      .vec_y (VW'(trig_ff[SQ].sinp)),
      .vec_x (VW'({1'b0, root_ff[SQ]})),
      .angle (pitch_r)
   );

   qte_cordic u_yaw (
      .clock (clock),
      .en    (en),
      .vec_y (VW'(trig_ff[SQ].siny)),
      .vec_x (VW'(trig_ff[SQ].cosy)),
      .angle (yaw_r)
   );

   function automatic logic signed [OW-1:0] clamp_ang(
      input logic signed [OW-1:0] a,
      input logic signed [OW-1:0] lim
   );
      logic signed [OW-1:0] r;
      r = a;
      if (a > lim) r = lim;
      if (a < -lim) r = -lim;
      return r;
   endfunction

   always_comb begin
      if (side_ff[SIDE_LEN-1].sat) begin
         pitch_c = side_ff[SIDE_LEN-1].neg ? -qte_pkg::HALF_PI_Q13 : qte_pkg::HALF_PI_Q13;
      end else begin
         pitch_c = clamp_ang(pitch_r, qte_pkg::HALF_PI_Q13);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         roll_ff  <= 16'(clamp_ang(roll_r, qte_pkg::PI_Q13));
         yaw_ff   <= 16'(clamp_ang(yaw_r, qte_pkg::PI_Q13));
         pitch_ff <= 15'(pitch_c);
         sat_ff   <= side_ff[SIDE_LEN-1].sat;
      end
   end

   assign rsp_tvalid = valid_ff[LAT-1];
   assign rsp_tdata  = {1'b0, yaw_ff, pitch_ff, roll_ff};
   assign rsp_tuser  = sat_ff;

endmodule
`default_nettype wire

>>> tb/quaternion_checker.sv
// Scoreboard for the quaternion to Euler angle converter: watches both streams,
// predicts roll/pitch/yaw for every accepted quaternion and compares in order.
// Depends only on the port layout of quaternion_to_euler_angles.
`timescale 1ns / 100ps
module quaternion_checker (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_tvalid,
   input  wire        req_tready,
   input  wire [63:0] req_tdata,
   input  wire        rsp_tvalid,
   input  wire        rsp_tready,
   input  wire [47:0] rsp_tdata,
   input  wire        rsp_tuser,
   output int         fail_count,
   output int         pending,
   output int         angles_seen,
   output int         saturated_seen
);

   localparam longint PI_Q13      = 25736;
   localparam longint HALF_PI_Q13 = 12868;
   localparam longint ANG_PI_Q16  = 205887;
   localparam longint ONE_Q28     = longint'(1) << 28;

   typedef struct packed {
      logic signed [15:0] roll;
      logic signed [14:0] pitch;
      logic signed [15:0] yaw;
      logic               sat;
   } euler_type;

   euler_type euler_queue[$];

   longint atan_steps[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                              256, 128, 64, 32, 16, 8, 4, 2};

   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = longint'(1) << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // vectoring CORDIC, angle in Q3.13 clamped to +-lim
   function automatic longint vector_angle(longint yv, longint xv, longint lim);
      longint x, y, z, r, dx, dy;
      x = xv;
      y = yv;
      z = 0;
      if (y == 0) begin
         r = (x < 0) ? PI_Q13 : 0;
      end else if (x == 0) begin
         r = (y > 0) ? HALF_PI_Q13 : -HALF_PI_Q13;
      end else begin
         if (x < 0) begin
            z = (y > 0) ? ANG_PI_Q16 : -ANG_PI_Q16;
            x = -x;
            y = -y;
         end
         for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
               x = x + dx;
               y = y - dy;
               z = z + atan_steps[i];
            end else begin
               x = x - dx;
               y = y + dy;
               z = z - atan_steps[i];
            end
         end
         r = (z + 4) >>> 3;
      end
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r;
   endfunction

   function automatic euler_type predict_euler(logic [63:0] q);
      longint w, x, y, z, sinr, cosr, siny, cosy, sinp, mag, p;
      longint unsigned c;
      euler_type e;
      w = longint'($signed(q[15:0]));
      x = longint'($signed(q[31:16]));
      y = longint'($signed(q[47:32]));
      z = longint'($signed(q[63:48]));
      sinr = 2 * (w * x + y * z);
      cosr = ONE_Q28 - 2 * (x * x + y * y);
      siny = 2 * (w * z + x * y);
      cosy = ONE_Q28 - 2 * (y * y + z * z);
      sinp = 2 * (w * y - z * x);
      mag = (sinp < 0) ? -sinp : sinp;
      e.roll = 16'(vector_angle(sinr, cosr, PI_Q13));
      e.yaw  = 16'(vector_angle(siny, cosy, PI_Q13));
      if (mag >= ONE_Q28) begin
         p = (sinp > 0) ? HALF_PI_Q13 : -HALF_PI_Q13;
         e.sat = 1'b1;
      end else begin
         c = floor_sqrt((longint'(1) << 56) - longint'(mag * mag));
         p = vector_angle(sinp, longint'(c), HALF_PI_Q13);
         e.sat = 1'b0;
      end
      e.pitch = 15'(p);
      return e;
   endfunction

   initial begin
      fail_count = 0;
      pending = 0;
      angles_seen = 0;
      saturated_seen = 0;
   end

   always @(posedge clock) begin
      euler_type want, got;
      if (!reset) begin
         if (req_tvalid && req_tready) euler_queue.push_back(predict_euler(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got.roll  = rsp_tdata[15:0];
            got.pitch = rsp_tdata[30:16];
            got.yaw   = rsp_tdata[46:31];
            got.sat   = rsp_tuser;
            angles_seen++;
            if (got.sat) saturated_seen++;
            if (euler_queue.size() == 0) begin
               $display("%0t: unexpected word roll=%0d pitch=%0d yaw=%0d sat=%0b",
                        $time, got.roll, got.pitch, got.yaw, got.sat);
               fail_count++;
            end else begin
               want = euler_queue.pop_front();
               if (got.roll !== want.roll) begin
                  $display("%0t: roll expected %0d actual %0d", $time, want.roll, got.roll);
                  fail_count++;
               end
               if (got.pitch !== want.pitch) begin
                  $display("%0t: pitch expected %0d actual %0d", $time, want.pitch,
                           got.pitch);
                  fail_count++;
               end
               if (got.yaw !== want.yaw) begin
                  $display("%0t: yaw expected %0d actual %0d", $time, want.yaw, got.yaw);
                  fail_count++;
               end
               if (got.sat !== want.sat) begin
                  $display("%0t: saturation expected %0b actual %0b", $time, want.sat,
                           got.sat);
                  fail_count++;
               end
            end
         end
      end
      pending = euler_queue.size();
   end

endmodule

>>> tb/testbench.sv
// Top of the converter testbench: clock, reset, quaternion stimulus and verdict.
// Depends on quaternion_to_euler_angles and quaternion_checker.
`timescale 1ns / 100ps
module testbench;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;   // quat_w[15:0], quat_x[31:16], quat_y[47:32], quat_z[63:48]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;   // roll_angle[15:0], pitch_angle[30:16], yaw_angle[46:31], 0
   logic        rsp_tuser;   // pitch_saturated

   int fail_count, pending, angles_seen, saturated_seen;
   int idle_pct, stall_pct, sent, quiet_cycles;
   bit held;

   quaternion_to_euler_angles dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   quaternion_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .fail_count(fail_count), .pending(pending),
      .angles_seen(angles_seen), .saturated_seen(saturated_seen)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   task automatic send_quat(logic signed [15:0] w, logic signed [15:0] x,
                            logic signed [15:0] y, logic signed [15:0] z);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {z, y, x, w};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
      @(negedge clock);
   endtask

   function automatic logic signed [15:0] rand_comp();
      int r;
      r = $urandom_range(9);
      if (r == 0) return 16'sd0;
      if (r == 1) return ($urandom_range(1)) ? 16'sd16384 : -16'sd16384;
      if (r == 2) return 16'($signed($urandom_range(512)) - 256);
      return 16'($signed($urandom_range(32768)) - 16384);
   endfunction

   // receiver: random stalls, plus one long hold-off to back up the pipe
   initial begin
      held = 0;
      rsp_tready = 1'b1;
      forever begin
         @(negedge clock);
         if (!held && sent == 40) begin
            held = 1;
            rsp_tready <= 1'b0;
            repeat (300) @(negedge clock);
         end
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // watchdog on cycles with no accepted word on either side
   initial begin
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= 5000) begin
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      idle_pct = 0;
      stall_pct = 0;
      sent = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // field extremes, identity, saturated pitch both signs, atan2 corner cases
      send_quat(0, 0, 0, 0);
      send_quat(16384, 0, 0, 0);
      send_quat(-16384, 0, 0, 0);
      send_quat(0, 16384, 0, 0);       // sine zero, cosine negative
      send_quat(0, -16384, 0, 0);
      send_quat(0, 0, 16384, 0);
      send_quat(0, 0, 0, -16384);
      send_quat(16384, 16384, 16384, 16384);
      send_quat(-16384, -16384, -16384, -16384);
      send_quat(0, 8192, 8192, 0);     // both operands zero
      send_quat(8192, 8192, 8192, 0);  // cosine operand zero
      send_quat(8192, 0, 8192, 8192);
      send_quat(16384, 0, 16384, 0);   // pitch clamps positive
      send_quat(-16384, 0, 16384, 0);  // pitch clamps negative
      send_quat(11586, 0, 11586, 0);   // just over the clamp
      send_quat(11585, 0, 11585, 0);   // just under it
      send_quat(11585, 0, -11585, 0);
      send_quat(0, 16384, 0, 16384);
      send_quat(1, -1, 1, -1);
      send_quat(16384, -16384, 16384, -16384);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 83; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 83; end
            default: begin idle_pct = 6; stall_pct = 6; end
         endcase
         repeat (120) send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
      end
      req_tvalid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("Sent %0d quaternions across four stall/idle mixes with one long hold-off;",
               sent);
      $display("checked %0d angle words, %0d with pitch clamped.", angles_seen,
               saturated_seen);
      if (fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

>>> filelist.f
sv/qte_pkg.sv
sv/qte_cordic.sv
sv/quaternion_to_euler_angles.sv
tb/quaternion_checker.sv
tb/testbench.sv
